>>> hw/rtl/dbrf_pkg.sv
// Shared types and constants for the binary record framer.
package dbrf_pkg;

    // Request codes carried by req_type
    typedef enum logic [1:0] {
        REQ_DATA     = 2'd0,
        REQ_START    = 2'd1,
        REQ_PAD      = 2'd2,
        REQ_RESERVED = 2'd3
    } req_t;

    // One step of the sequencer; the frame byte slots ST_HDR0 to ST_PAD are in emission order
    typedef enum logic [3:0] {
        ST_HDR0,
        ST_HDR1,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_ADDR_LO,
        ST_ADDR_HI,
        ST_DATA,
        ST_CKSUM,
        ST_PAD,
        ST_DROP,
        ST_START_CK,
        ST_FILL,
        ST_ALIGNED,
        ST_NOP
    } step_t;

    localparam logic [7:0]  HDR_MARK0     = 8'h01;
    localparam logic [7:0]  HDR_MARK1     = 8'h00;
    localparam logic [8:0]  HDR_LEN_BIAS  = 9'd6;
    localparam logic [7:0]  START_LEN     = 8'd6;
    // 01 + 00 + 06 + 00 of a start frame header
    localparam logic [7:0]  START_HDR_SUM = 8'd7;
    localparam logic [16:0] ADDR_SPACE    = 17'h10000;

    // Input beat as held in the item register
    typedef struct packed {
        req_t        req;
        logic        first;
        logic        last;
        logic [15:0] address;
        logic [7:0]  length;
        logic [7:0]  data;
    } dbrf_item_t;

    // Stream state seen by the step logic
    typedef struct packed {
        logic       start_enable;
        logic       dropping;
        logic [7:0] sum;
        logic       offset_odd;
        logic       offset_aligned;
    } dbrf_ctx_t;

    // State updates produced with each result
    typedef struct packed {
        logic       last;
        logic       adv_offset;
        logic [7:0] sum_next;
        logic       dropping_next;
    } dbrf_upd_t;

    // One result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       range_error;
        logic       block_aligned;
    } dbrf_result_t;

endpackage

>>> hw/rtl/dec_binary_record_framer.sv
// Top level of the binary record framer: beat registers, stream state, output register.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     req_type .. data_byte
//   out      output     out_valid / out_ready   out_byte .. block_aligned
//   cfg      input      cfg_wr_en               cfg_wr_data (start_address_enable)
//
// Each input beat yields 1 to 9 output beats, one per cycle while out is not
// stalled: one for a plain data byte, up to 9 for a record's first-and-last
// byte. The item register feeds one step slot per cycle into the output register;
// the next beat is taken in the cycle its predecessor's last result is emitted.
// Reset clears the stream offset, sum and drop flag and sets start_address_enable.
// A stall on out holds the output register and the item.
module dec_binary_record_framer
    import dbrf_pkg::*;
#(
    parameter int BLOCK_BYTES      = 512,
    parameter int MAX_RECORD_BYTES = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic        first_of_record,
    input  logic        last_of_record,
    input  logic [15:0] rec_address,
    input  logic [7:0]  rec_length,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        last_in_run,
    output logic        range_error,
    output logic        block_aligned
);

    localparam int            OFF_W    = $clog2(2 * BLOCK_BYTES);
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(2 * BLOCK_BYTES - 1);
    localparam logic [OFF_W-1:0] OFF_HALF = OFF_W'(BLOCK_BYTES);

    logic             start_enable_reg;
    logic             item_valid_reg;
    logic             entry_reg;
    dbrf_item_t       item_reg;
    step_t            step_reg;
    logic [OFF_W-1:0] offset_reg;
    logic [7:0]       running_sum_reg;
    logic             dropping_reg;
    logic             out_valid_reg;
    dbrf_result_t     res_reg;
    logic             res_last_reg;

    dbrf_ctx_t        ctx;
    dbrf_upd_t        upd;
    dbrf_result_t     res;
    step_t            step_cur;
    step_t            step_next;
    logic             emit;
    logic             in_accept;
    logic [OFF_W-1:0] offset_next;

    // Stream context for the step logic
    assign ctx.start_enable   = start_enable_reg;
    assign ctx.dropping       = dropping_reg;
    assign ctx.sum            = running_sum_reg;
    assign ctx.offset_odd     = offset_reg[0];
    assign ctx.offset_aligned = (offset_reg == '0) || (offset_reg == OFF_HALF);

    dbrf_step #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
    ) u_step (
        .item     (item_reg),
        .entry    (entry_reg),
        .step_in  (step_reg),
        .ctx      (ctx),
        .step_cur (step_cur),
        .step_next(step_next),
        .upd      (upd),
        .res      (res)
    );

    // Handshake: emit when the output register is free; take a beat as the item ends
    assign emit      = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || (emit && upd.last);
    assign in_accept = in_valid && in_ready;

    assign offset_next = (offset_reg == OFF_LAST) ? '0 : offset_reg + OFF_W'(1);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_enable_reg <= 1'b1;
        else if (cfg_wr_en)
            start_enable_reg <= cfg_wr_data;
    end

    // Item register and step sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            entry_reg      <= 1'b1;
            step_reg       <= ST_NOP;
        end
        else if (in_accept)
        begin
            item_valid_reg <= 1'b1;
            entry_reg      <= 1'b1;
        end
        else if (emit)
        begin
            if (upd.last)
                item_valid_reg <= 1'b0;
            entry_reg <= upd.last;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.req     <= req_t'(req_type);
            item_reg.first   <= first_of_record;
            item_reg.last    <= last_of_record;
            item_reg.address <= rec_address;
            item_reg.length  <= rec_length;
            item_reg.data    <= data_byte;
        end
    end

    // Stream state: update on every emitted result; the offset advances only for stream bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg      <= '0;
            running_sum_reg <= 8'h00;
            dropping_reg    <= 1'b0;
        end
        else if (emit)
        begin
            if (upd.adv_offset)
                offset_reg <= offset_next;
            running_sum_reg <= upd.sum_next;
            dropping_reg    <= upd.dropping_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg      <= res;
            res_last_reg <= upd.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = res_reg.out_byte;
    assign byte_valid    = res_reg.byte_valid;
    assign last_in_run   = res_last_reg;
    assign range_error   = res_reg.range_error;
    assign block_aligned = res_reg.block_aligned;

    // Offset stays inside its modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg <= OFF_LAST)
        else $error("stream offset out of range");

    // A closed data frame leaves the stream at an even offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && upd.last && (step_cur == ST_CKSUM || step_cur == ST_PAD))
        |=> !offset_reg[0])
        else $error("frame closed at odd offset");

    // The checksum byte brings the frame sum back to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && step_cur == ST_CKSUM) |=> (running_sum_reg == 8'h00))
        else $error("frame sum not zero after checksum");

    // A dropped-record result never carries a stream byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.range_error)
        |-> (!res_reg.byte_valid && res_reg.out_byte == 8'h00))
        else $error("dropped record emitted a byte");

endmodule

>>> hw/rtl/dbrf_step.sv
// Frame sequencer step: picks the current byte slot, its result and the state updates.
module dbrf_step
    import dbrf_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = 255
)
(
    input  dbrf_item_t   item,
    input  logic         entry,
    input  step_t        step_in,
    input  dbrf_ctx_t    ctx,
    output step_t        step_cur,
    output step_t        step_next,
    output dbrf_upd_t    upd,
    output dbrf_result_t res
);

    logic [16:0] end_addr;
    logic        bad_record;
    logic [8:0]  len_word;
    logic        is_data;
    logic        slot_last;

    // Judge the record on its first byte
    assign end_addr   = {1'b0, item.address} + {9'b0, item.length};
    assign bad_record = (item.length == 8'd0)
                     || ({9'b0, item.length} > 17'(MAX_RECORD_BYTES))
                     || (end_addr > ADDR_SPACE);
    assign len_word   = {1'b0, item.length} + HDR_LEN_BIAS;
    assign is_data    = (item.req == REQ_DATA);

    // Next state: entry slot of a new beat, then the slot after the current one
    always_comb
    begin
        step_cur = step_in;
        if (entry)
        begin
            case (item.req)
                REQ_DATA:
                begin
                    if (item.first)
                        step_cur = bad_record ? ST_DROP : ST_HDR0;
                    else
                        step_cur = ctx.dropping ? ST_DROP : ST_DATA;
                end
                REQ_START: step_cur = ctx.start_enable ? ST_HDR0 : ST_NOP;
                REQ_PAD:   step_cur = ctx.offset_aligned ? ST_ALIGNED : ST_FILL;
                default:   step_cur = ST_NOP;
            endcase
        end

        step_next = step_cur;
        slot_last = 1'b1;
        case (step_cur)
            ST_HDR0:    begin step_next = ST_HDR1;    slot_last = 1'b0; end
            ST_HDR1:    begin step_next = ST_LEN_LO;  slot_last = 1'b0; end
            ST_LEN_LO:  begin step_next = ST_LEN_HI;  slot_last = 1'b0; end
            ST_LEN_HI:  begin step_next = ST_ADDR_LO; slot_last = 1'b0; end
            ST_ADDR_LO: begin step_next = ST_ADDR_HI; slot_last = 1'b0; end
            ST_ADDR_HI:
            begin
                step_next = is_data ? ST_DATA : ST_START_CK;
                slot_last = 1'b0;
            end
            ST_DATA:
            begin
                step_next = ST_CKSUM;
                slot_last = !item.last;
            end
            ST_CKSUM:
            begin
                // offset after the checksum is odd exactly when it is even now
                step_next = ST_PAD;
                slot_last = ctx.offset_odd;
            end
            default:    slot_last = 1'b1;
        endcase
    end

    // Outputs: result byte and stream state updates for the current slot
    always_comb
    begin
        upd.last          = slot_last;
        res.out_byte      = 8'h00;
        res.byte_valid    = 1'b1;
        res.range_error   = 1'b0;
        res.block_aligned = 1'b0;
        upd.adv_offset    = 1'b1;
        upd.dropping_next = ctx.dropping;
        case (step_cur)
            ST_HDR0:
            begin
                res.out_byte = HDR_MARK0;
                if (is_data)
                    upd.dropping_next = 1'b0;
            end
            ST_HDR1:     res.out_byte = HDR_MARK1;
            ST_LEN_LO:   res.out_byte = is_data ? len_word[7:0] : START_LEN;
            ST_LEN_HI:   res.out_byte = is_data ? {7'b0, len_word[8]} : 8'h00;
            ST_ADDR_LO:  res.out_byte = item.address[7:0];
            ST_ADDR_HI:  res.out_byte = item.address[15:8];
            ST_DATA:     res.out_byte = item.data;
            ST_CKSUM:    res.out_byte = 8'h00 - ctx.sum;
            ST_PAD:      res.out_byte = 8'h00;
            ST_START_CK:
            begin
                res.out_byte = 8'h00 - (START_HDR_SUM + item.address[7:0]
                                        + item.address[15:8]);
            end
            ST_FILL:     res.out_byte = 8'h00;
            ST_DROP:
            begin
                res.byte_valid    = 1'b0;
                res.range_error   = 1'b1;
                upd.adv_offset    = 1'b0;
                upd.dropping_next = !item.last;
            end
            ST_ALIGNED:
            begin
                res.byte_valid    = 1'b0;
                res.block_aligned = 1'b1;
                upd.adv_offset    = 1'b0;
            end
            default:
            begin
                res.byte_valid = 1'b0;
                upd.adv_offset = 1'b0;
            end
        endcase

        // Only data frame bytes enter the running sum; the first header byte restarts it
        upd.sum_next = ctx.sum;
        if (is_data && res.byte_valid)
        begin
            if (step_cur == ST_HDR0)
                upd.sum_next = res.out_byte;
            else
                upd.sum_next = ctx.sum + res.out_byte;
        end
    end

endmodule
